>>> rtl/u8dic_pkg.sv
// shared types, constants and helpers of the utf-8 decoder and identifier classifier
package u8dic_pkg;

   localparam int CP_WIDTH     = 21;
   localparam int LEN_WIDTH    = 3;
   localparam int CJK_RANGES   = 9;

   // utf-8 lead and continuation patterns
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_MARK  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_MARK = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_MARK = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_MARK = 8'hF0;

   localparam logic [LEN_WIDTH-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_WIDTH-1:0] LEN_ONE  = 3'd1;
   localparam logic [LEN_WIDTH-1:0] LEN_TWO  = 3'd2;
   localparam logic [LEN_WIDTH-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_WIDTH-1:0] LEN_FOUR = 3'd4;

   // ideograph and fullwidth alphanumeric ranges, inclusive bounds
   localparam logic [CP_WIDTH-1:0] CJK_LO [CJK_RANGES] = '{
      21'h04E00, 21'h03400, 21'h20000, 21'h02E80, 21'h0F900,
      21'h2F800, 21'h0FF41, 21'h0FF21, 21'h0FF10
   };
   localparam logic [CP_WIDTH-1:0] CJK_HI [CJK_RANGES] = '{
      21'h09FFF, 21'h04DBF, 21'h2A6DF, 21'h02EFF, 21'h0FAFF,
      21'h2FA1F, 21'h0FF5A, 21'h0FF3A, 21'h0FF19
   };

   localparam logic [CP_WIDTH-1:0] LOWER_A    = 21'h61;
   localparam logic [CP_WIDTH-1:0] LOWER_Z    = 21'h7A;
   localparam logic [CP_WIDTH-1:0] UPPER_A    = 21'h41;
   localparam logic [CP_WIDTH-1:0] UPPER_Z    = 21'h5A;
   localparam logic [CP_WIDTH-1:0] UNDERSCORE = 21'h5F;
   localparam logic [CP_WIDTH-1:0] DIGIT_0    = 21'h30;
   localparam logic [CP_WIDTH-1:0] DIGIT_9    = 21'h39;

   typedef struct packed {
      logic [7:0] fourth_byte;
      logic [7:0] third_byte;
      logic [7:0] second_byte;
      logic [7:0] lead_byte;
   } window_type;

   typedef struct packed {
      logic                 valid_res;
      logic [LEN_WIDTH-1:0] seq_length;
      logic [CP_WIDTH-1:0]  code_point;
   } decode_type;

   typedef struct packed {
      logic [CJK_RANGES-1:0] cjk_hit;
      logic                  alpha_us;
      logic                  digit;
      decode_type            dec;
   } hits_type;

   typedef struct packed {
      logic       ident_continue;
      logic       ident_start;
      logic       cjk_char;
      decode_type dec;
   } result_type;

   function automatic logic is_cont(input logic [7:0] b);
      return (b & CONT_MASK) == CONT_MARK;
   endfunction

endpackage

>>> rtl/utf8_decode_ident_classify.sv
// top level of the utf-8 decoder and identifier classifier
// Decodes one utf-8 sequence from a four-byte window per item and flags the
// code point for identifier scanning. Items move through three register stages
// (decode, range compare, flag merge). A result is offered on rsp from the
// flag merge register after passing the decode and range compare registers.
// One item is taken every cycle as long as rsp_tready stays high;
// each stage holds its item when the next one is full and stalled, and ready
// ripples back through the stages. Only lead patterns and the
// 10xxxxxx marks are checked: overlong forms, surrogates and values above
// 0x10ffff come out as decoded. An invalid sequence gives code point zero,
// length zero and all flags clear. A zero lead byte is valid with length one.
module utf8_decode_ident_classify import u8dic_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // lead_byte, second_byte, third_byte, fourth_byte
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // code_point[20:0], seq_length[23:21], valid_res[24], cjk_char[25],
   // ident_start[26], ident_continue[27], zero fill
   output logic [31:0] rsp_tdata
);

   window_type window;
   decode_type dec_data;
   hits_type   hit_data;
   result_type res_data;
   logic       dec_valid, dec_ready;
   logic       hit_valid, hit_ready;

   assign window = window_type'(req_tdata);

   // decode of lead and continuation bytes
   u8dic_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (window),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   // ideograph, fullwidth, letter and digit range compares
   u8dic_ranges u_ranges (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (hit_valid),
      .out_ready (hit_ready),
      .out_data  (hit_data)
   );

   // flag merge, doubles as the output register
   u8dic_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hit_valid),
      .in_ready  (hit_ready),
      .in_data   (hit_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res_data)
   );

   assign rsp_tdata = {4'd0, res_data};

endmodule

>>> rtl/u8dic_decode.sv
// first stage: lead byte pattern check and code point assembly
module u8dic_decode import u8dic_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  window_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output decode_type out_data
);

   logic       valid_ff;
   logic       valid_in;
   decode_type data_ff;
   decode_type data_in;
   logic       c1, c2, c3;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      c1 = is_cont(in_data.second_byte);
      c2 = is_cont(in_data.third_byte);
      c3 = is_cont(in_data.fourth_byte);
      data_in = '0;
      if (!in_data.lead_byte[7]) begin
         data_in.code_point = {13'd0, in_data.lead_byte};
         data_in.seq_length = LEN_ONE;
         data_in.valid_res  = 1'b1;
      end else if ((in_data.lead_byte & LEAD2_MASK) == LEAD2_MARK) begin
         if (c1) begin
            data_in.code_point = {10'd0, in_data.lead_byte[4:0], in_data.second_byte[5:0]};
            data_in.seq_length = LEN_TWO;
            data_in.valid_res  = 1'b1;
         end
      end else if ((in_data.lead_byte & LEAD3_MASK) == LEAD3_MARK) begin
         if (c1 && c2) begin
            data_in.code_point = {5'd0, in_data.lead_byte[3:0], in_data.second_byte[5:0],
                                  in_data.third_byte[5:0]};
            data_in.seq_length = LEN_THREE;
            data_in.valid_res  = 1'b1;
         end
      end else if ((in_data.lead_byte & LEAD4_MASK) == LEAD4_MARK) begin
         if (c1 && c2 && c3) begin
            data_in.code_point = {in_data.lead_byte[2:0], in_data.second_byte[5:0],
                                  in_data.third_byte[5:0], in_data.fourth_byte[5:0]};
            data_in.seq_length = LEN_FOUR;
            data_in.valid_res  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/u8dic_ranges.sv
// second stage: range compares of the decoded code point
module u8dic_ranges import u8dic_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  decode_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output hits_type   out_data
);

   logic     valid_ff;
   logic     valid_in;
   hits_type data_ff;
   hits_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in.dec = in_data;
      for (int i = 0; i < CJK_RANGES; i++) begin
         data_in.cjk_hit[i] = (in_data.code_point >= CJK_LO[i]) &&
                              (in_data.code_point <= CJK_HI[i]);
      end
      data_in.alpha_us = ((in_data.code_point >= LOWER_A) && (in_data.code_point <= LOWER_Z)) ||
                         ((in_data.code_point >= UPPER_A) && (in_data.code_point <= UPPER_Z)) ||
                         (in_data.code_point == UNDERSCORE);
      data_in.digit    = (in_data.code_point >= DIGIT_0) && (in_data.code_point <= DIGIT_9);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/u8dic_classify.sv
// third stage: class flag merge into the output register
module u8dic_classify import u8dic_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  hits_type   in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;
   result_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // an invalid sequence carries code point zero, which hits no range
   always_comb begin
      data_in.dec            = in_data.dec;
      data_in.cjk_char       = |in_data.cjk_hit;
      data_in.ident_start    = data_in.cjk_char || in_data.alpha_us;
      data_in.ident_continue = data_in.ident_start || in_data.digit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/u8dic_checker.sv
// port-level assertions for the utf-8 decoder and identifier classifier
module u8dic_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item dropped or changed under stall");

   // invalid sequence gives an all-zero item
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[24] |-> rsp_tdata == 32'd0)
      else $error("invalid item carries nonzero fields");

   // class flags nest: cjk within start within continue
   a_flag_nest: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[25] || rsp_tdata[26]) && (!rsp_tdata[26] || rsp_tdata[27]))
      else $error("class flags inconsistent");

   // a valid item has a length of one to four
   a_valid_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[24] |->
         (rsp_tdata[23:21] == 3'd1 || rsp_tdata[23:21] == 3'd2 ||
          rsp_tdata[23:21] == 3'd3 || rsp_tdata[23:21] == 3'd4))
      else $error("valid item with bad length");

   // a single-byte item is plain ascii
   a_ascii_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23:21] == 3'd1 |-> rsp_tdata[20:7] == 14'd0)
      else $error("single-byte item above ascii");

endmodule

bind utf8_decode_ident_classify u8dic_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
